// ===== src/lts_pkg.sv =====
// Shared types, codes and the per-pass scan function of the Lisp token scanner.
package lts_pkg;

    // Result buffer sizing.
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Character that opens a comment at the start of a line.
    localparam logic [7:0] HASH_CHAR = 8'h23;

    // Syntax classes of the input character.
    localparam logic [4:0] CL_OTHER    = 5'd0;
    localparam logic [4:0] CL_SHELL    = 5'd1;
    localparam logic [4:0] CL_COMMENT  = 5'd2;
    localparam logic [4:0] CL_SEP      = 5'd3;
    localparam logic [4:0] CL_NEWLINE  = 5'd4;
    localparam logic [4:0] CL_LPAREN   = 5'd5;
    localparam logic [4:0] CL_RPAREN   = 5'd6;
    localparam logic [4:0] CL_LBRACK   = 5'd7;
    localparam logic [4:0] CL_RBRACK   = 5'd8;
    localparam logic [4:0] CL_QUOTE    = 5'd9;
    localparam logic [4:0] CL_DOT      = 5'd10;
    localparam logic [4:0] CL_STRDELIM = 5'd11;
    localparam logic [4:0] CL_SIGN     = 5'd12;
    localparam logic [4:0] CL_DIGIT    = 5'd13;
    localparam logic [4:0] CL_MACRO    = 5'd14;
    localparam logic [4:0] CL_SPLICE   = 5'd15;
    localparam logic [4:0] CL_INFIX    = 5'd16;
    localparam logic [4:0] CL_ESCAPE   = 5'd17;
    localparam logic [4:0] CL_EXPONENT = 5'd18;

    typedef enum logic [2:0] {
        TK_SYMBOL  = 3'd0,
        TK_SPECIAL = 3'd1,
        TK_STRING  = 3'd2,
        TK_INT     = 3'd3,
        TK_FLOAT   = 3'd4,
        TK_MACRO   = 3'd5,
        TK_SPLICE  = 3'd6,
        TK_INFIX   = 3'd7
    } tok_kind_t;

    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_SYMBOL  = 4'd1,
        ST_SYMESC  = 4'd2,
        ST_QUOTE   = 4'd3,
        ST_STRING  = 4'd4,
        ST_COMMENT = 4'd5,
        ST_HASH    = 4'd6,
        ST_SIGN    = 4'd7,
        ST_INT     = 4'd8,
        ST_FLOAT   = 4'd9,
        ST_EXP1    = 4'd10,
        ST_EXP2    = 4'd11,
        ST_DOT     = 4'd12
    } scan_state_t;

    // One result item.
    typedef struct packed {
        logic        is_end;
        logic [7:0]  ch;
        tok_kind_t   kind;
        logic        last;
    } result_t;

    // Results produced by one accepted request.
    typedef struct packed {
        logic [1:0]          n;
        result_t [MAX_RES-1:0] res;
    } step_t;

    // Scanner status seen by the top level.
    typedef struct packed {
        scan_state_t st;
        tok_kind_t   kind;
        logic        line_start;
    } core_status_t;

    // Result buffer status seen by the top level.
    typedef struct packed {
        logic [FIFO_CW-1:0] count;
    } fifo_status_t;

    // Working set carried from one scan pass to the next.
    typedef struct packed {
        scan_state_t           st;
        tok_kind_t             kind;
        logic                  again;
        logic [1:0]            n;
        result_t [MAX_RES-1:0] res;
    } pass_t;

    function automatic logic is_term(logic [4:0] cl);
        return (cl >= CL_SEP) && (cl <= CL_RBRACK);
    endfunction

    // Append a result unless the list is already full.
    function automatic pass_t emit(pass_t p, logic is_end, logic [7:0] c, tok_kind_t k);
        pass_t q;
        q = p;
        if (q.n != 2'd3) begin
            q.res[q.n].is_end = is_end;
            q.res[q.n].ch     = c;
            q.res[q.n].kind   = k;
            q.res[q.n].last   = 1'b0;
            q.n               = q.n + 2'd1;
        end
        return q;
    endfunction

    // Emit the end marker of the open token and go back to the start state.
    function automatic pass_t end_token(pass_t p);
        pass_t q;
        q      = emit(p, 1'b1, 8'h00, p.kind);
        q.st   = ST_START;
        q.kind = TK_SYMBOL;
        return q;
    endfunction

    // One scan of the character from the current state; again asks for a rescan.
    function automatic pass_t scan_pass(pass_t p, logic [7:0] ch, logic [4:0] cl, logic ls);
        pass_t q;
        q       = p;
        q.again = 1'b0;
        unique case (p.st)
            ST_START: begin
                if (ls && ch == HASH_CHAR) begin
                    q.st = ST_COMMENT;
                end else begin
                    case (cl) inside
                        CL_SHELL: begin
                            if (ls) begin
                                q.st = ST_COMMENT;
                            end else begin
                                q.st   = ST_HASH;
                                q.kind = TK_SYMBOL;
                                q      = emit(q, 1'b0, ch, q.kind);
                            end
                        end
                        CL_COMMENT: q.st = ST_COMMENT;
                        CL_SEP, CL_NEWLINE: ;
                        CL_LPAREN, CL_RPAREN, CL_LBRACK, CL_RBRACK, CL_QUOTE: begin
                            q.kind = TK_SPECIAL;
                            q      = emit(q, 1'b0, ch, q.kind);
                            q      = end_token(q);
                        end
                        CL_DOT: begin
                            q.st   = ST_DOT;
                            q.kind = TK_SPECIAL;
                            q      = emit(q, 1'b0, ch, q.kind);
                        end
                        CL_STRDELIM: begin
                            q.st   = ST_STRING;
                            q.kind = TK_STRING;
                        end
                        CL_SIGN: begin
                            q.st   = ST_SIGN;
                            q.kind = TK_SYMBOL;
                            q      = emit(q, 1'b0, ch, q.kind);
                        end
                        CL_DIGIT: begin
                            q.st   = ST_INT;
                            q.kind = TK_INT;
                            q      = emit(q, 1'b0, ch, q.kind);
                        end
                        CL_MACRO, CL_SPLICE, CL_INFIX: begin
                            if (cl == CL_MACRO) begin
                                q.kind = TK_MACRO;
                            end else if (cl == CL_SPLICE) begin
                                q.kind = TK_SPLICE;
                            end else begin
                                q.kind = TK_INFIX;
                            end
                            q = emit(q, 1'b0, ch, q.kind);
                            q = end_token(q);
                        end
                        default: begin
                            q.st   = ST_SYMBOL;
                            q.kind = TK_SYMBOL;
                            q      = emit(q, 1'b0, ch, q.kind);
                        end
                    endcase
                end
            end
            ST_SYMBOL: begin
                if (cl == CL_COMMENT || is_term(cl)) begin
                    q       = end_token(q);
                    q.again = 1'b1;
                end else if (cl == CL_ESCAPE) begin
                    q.st = ST_SYMESC;
                end else begin
                    q = emit(q, 1'b0, ch, q.kind);
                end
            end
            ST_SYMESC: begin
                q    = emit(q, 1'b0, ch, q.kind);
                q.st = ST_SYMBOL;
            end
            ST_QUOTE: begin
                q    = emit(q, 1'b0, ch, q.kind);
                q.st = ST_STRING;
            end
            ST_STRING: begin
                if (cl == CL_ESCAPE) begin
                    q.st = ST_QUOTE;
                end else if (cl == CL_STRDELIM) begin
                    q = end_token(q);
                end else begin
                    q = emit(q, 1'b0, ch, q.kind);
                end
            end
            ST_COMMENT: begin
                if (cl == CL_NEWLINE) begin
                    q.st = ST_START;
                end
            end
            ST_HASH: begin
                if (is_term(cl)) begin
                    q       = end_token(q);
                    q.again = 1'b1;
                end else if (cl == CL_QUOTE) begin
                    q = emit(q, 1'b0, ch, q.kind);
                    q = end_token(q);
                end else begin
                    q = emit(q, 1'b0, ch, q.kind);
                end
            end
            ST_SIGN: begin
                if (cl == CL_DIGIT) begin
                    q.st   = ST_INT;
                    q.kind = TK_INT;
                    q      = emit(q, 1'b0, ch, q.kind);
                end else begin
                    q.st    = ST_SYMBOL;
                    q.kind  = TK_SYMBOL;
                    q.again = 1'b1;
                end
            end
            ST_INT, ST_FLOAT, ST_EXP1, ST_EXP2: begin
                if (cl == CL_COMMENT || is_term(cl)) begin
                    q       = end_token(q);
                    q.again = 1'b1;
                end else begin
                    // Number promotion; anything unexpected turns it into a symbol.
                    if (p.st == ST_INT && cl == CL_DOT) begin
                        q.st   = ST_FLOAT;
                        q.kind = TK_FLOAT;
                    end else if ((p.st == ST_INT || p.st == ST_FLOAT) && cl == CL_EXPONENT) begin
                        q.st   = ST_EXP1;
                        q.kind = TK_FLOAT;
                    end else if (cl == CL_DIGIT && p.st != ST_EXP1) begin
                        q.st = p.st;
                    end else if (p.st == ST_EXP1 && (cl == CL_SIGN || cl == CL_DIGIT)) begin
                        q.st = ST_EXP2;
                    end else begin
                        q.st   = ST_SYMBOL;
                        q.kind = TK_SYMBOL;
                    end
                    q = emit(q, 1'b0, ch, q.kind);
                end
            end
            ST_DOT: begin
                if (cl == CL_COMMENT || is_term(cl)) begin
                    q       = end_token(q);
                    q.again = 1'b1;
                end else if (cl == CL_DIGIT) begin
                    q.st    = ST_FLOAT;
                    q.kind  = TK_FLOAT;
                    q.again = 1'b1;
                end else begin
                    q.st    = ST_SYMBOL;
                    q.kind  = TK_SYMBOL;
                    q.again = 1'b1;
                end
            end
            default: begin
                q.st    = ST_START;
                q.kind  = TK_SYMBOL;
                q.again = 1'b1;
            end
        endcase
        return q;
    endfunction

endpackage

// ===== src/lts_scan_core.sv =====
// Scanner state registers and the per-request result logic.
module lts_scan_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    input  logic [4:0]           char_class,
    input  logic                 end_of_input,
    output lts_pkg::step_t       step,
    output lts_pkg::core_status_t status
);
    import lts_pkg::*;

    scan_state_t state_reg, state_next;
    tok_kind_t   kind_reg, kind_next;
    logic        line_start_reg, line_start_next;

    logic [4:0]  cl_eff;
    pass_t       p0, p1, p2, p3, p4, pf;

    // Unknown classes scan as ordinary characters.
    assign cl_eff = (char_class > CL_EXPONENT) ? CL_OTHER : char_class;

    // Up to four scans of the same character: terminators are rescanned.
    always_comb begin
        p0       = '0;
        p0.st    = state_reg;
        p0.kind  = kind_reg;
        p0.again = 1'b1;
        p1 = p0.again ? scan_pass(p0, char_code, cl_eff, line_start_reg) : p0;
        p2 = p1.again ? scan_pass(p1, char_code, cl_eff, line_start_reg) : p1;
        p3 = p2.again ? scan_pass(p2, char_code, cl_eff, line_start_reg) : p2;
        p4 = p3.again ? scan_pass(p3, char_code, cl_eff, line_start_reg) : p3;
    end

    // Flush closes an open token; otherwise take the scan result.
    always_comb begin
        if (end_of_input) begin
            pf       = '0;
            pf.st    = state_reg;
            pf.kind  = kind_reg;
            if (state_reg != ST_START && state_reg != ST_COMMENT) begin
                pf = end_token(pf);
            end
            pf.st   = ST_START;
            pf.kind = TK_SYMBOL;
        end else begin
            pf = p4;
        end
        step.n   = pf.n;
        step.res = pf.res;
        if (pf.n != 2'd0) begin
            step.res[pf.n - 2'd1].last = 1'b1;
        end
    end

    // Next scanner state for an accepted request.
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        line_start_next = line_start_reg;
        if (accept) begin
            state_next = pf.st;
            kind_next  = pf.kind;
            if (!end_of_input) begin
                line_start_next = (cl_eff == CL_NEWLINE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_START;
            kind_reg       <= TK_SYMBOL;
            line_start_reg <= 1'b1;
        end else begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            line_start_reg <= line_start_next;
        end
    end

    assign status.st         = state_reg;
    assign status.kind       = kind_reg;
    assign status.line_start = line_start_reg;

endmodule

// ===== src/lts_result_fifo.sv =====
// Result buffer: takes up to three results per cycle, delivers one per cycle while m_tready is high.
module lts_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lts_pkg::step_t        step,
    output logic                  room,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output lts_pkg::result_t      m_res,
    output lts_pkg::fifo_status_t status
);
    import lts_pkg::*;

    localparam logic [FIFO_CW-1:0] ROOM_LIMIT = FIFO_CW'(FIFO_DEPTH - MAX_RES);

    result_t              buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n   = push ? step.n : 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg <= ROOM_LIMIT);
    assign m_tvalid = (count_reg != '0);
    assign m_res    = buf_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the new results at consecutive slots.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < push_n) begin
                buf_reg[wr_ptr_reg + FIFO_AW'(i)] <= step.res[i];
            end
        end
    end

    assign status.count = count_reg;

endmodule

// ===== src/lisp_token_scanner.sv =====
// Top level of the Lisp token scanner: stream ports, scanner and result buffer.
//
// The scanner accepts one character request per cycle while its result buffer
// has room for three more results, and emits each token character as it is
// consumed plus an end marker carrying the token type when the token closes.
// A request yields zero to three results; the output side delivers one result
// per cycle while m_tready is high, so the sustained rate is one request per
// cycle while requests average at most one result, and is otherwise set by the
// single output port draining the eight-entry result buffer. All scanning of a
// character, including the rescan of a terminator, happens in the cycle it is
// accepted; its results are registered in the result buffer that drives the output.
module lisp_token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [12:8] char_class, [15:13] zero
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [10:8] token_kind, [15:11] zero
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast
);
    import lts_pkg::*;

    logic         accept;
    logic         room;
    step_t        step;
    result_t      m_res;
    core_status_t core_status;
    fifo_status_t fifo_status;
    logic [1:0]   push_count;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    lts_scan_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_code    (s_tdata[7:0]),
        .char_class   (s_tdata[12:8]),
        .end_of_input (s_tuser),
        .step         (step),
        .status       (core_status)
    );

    lts_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .step     (step),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .status   (fifo_status)
    );

    // Output packing.
    assign m_tdata = {5'b0, m_res.kind, m_res.ch};
    assign m_tuser = m_res.is_end;
    assign m_tlast = m_res.last;

    // Number of results pushed by the current request.
    assign push_count = accept ? step.n : 2'd0;

    // The buffer fill tracks what was pushed and popped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fifo_status.count == $past(fifo_status.count)
            + FIFO_CW'($past(push_count)) - FIFO_CW'($past(m_tvalid && m_tready)))
        else $error("result buffer fill count out of step");

    // Every request that yields results marks its final one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step.n != 2'd0) |-> step.res[step.n - 2'd1].last)
        else $error("final result of a request not marked last");

    // A flush always leaves the scanner in the start state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> (core_status.st == ST_START && core_status.kind == TK_SYMBOL))
        else $error("flush did not return scanner to start");

endmodule

// ===== tb/lisp_token_scanner_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Lisp token scanner, with its own tokenizer predictor.
module lisp_token_scanner_test;
    import lts_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int DIR_ROWS     = 31;

    // Classes above the named range behave as plain characters.
    localparam logic [4:0] CL_TOP = 5'd31;

    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
        tok_kind_t  kind;
        logic       last;
    } scan_result_t;

    typedef struct packed {
        logic [7:0] code;
        logic [4:0] cls;
        logic       flush;
    } char_req_t;

    // One directed row: the request and, where obvious, its results typed in.
    typedef struct packed {
        char_req_t    req;
        logic         typed;
        logic [1:0]   n_typed;
        scan_result_t r0;
        scan_result_t r1;
    } dir_row_t;

    localparam scan_result_t NO_RES = '0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] char_code, [12:8] char_class, [15:13] zero
    logic        s_tuser;   // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_char, [10:8] token_kind, [15:11] zero
    logic        m_tuser;   // [0] result_kind
    logic        m_tlast;

    lisp_token_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Directed requests: comments, escapes, every class but the right parenthesis, number promotion and flushes.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{8'h23, CL_OTHER, 1'b0}, TYPED, 2'd0, NO_RES, NO_RES},
        '{'{8'h0a, CL_NEWLINE, 1'b0}, TYPED, 2'd0, NO_RES, NO_RES},
        '{'{8'h28, CL_LPAREN, 1'b0}, TYPED, 2'd2, '{1'b0, 8'h28, TK_SPECIAL, 1'b0},
          '{1'b1, 8'h00, TK_SPECIAL, 1'b1}},
        '{'{8'hff, CL_TOP, 1'b0}, TYPED, 2'd1, '{1'b0, 8'hff, TK_SYMBOL, 1'b1}, NO_RES},
        '{'{8'h00, CL_ESCAPE, 1'b0}, TYPED, 2'd0, NO_RES, NO_RES},
        '{'{8'h28, CL_LPAREN, 1'b0}, TYPED, 2'd1, '{1'b0, 8'h28, TK_SYMBOL, 1'b1}, NO_RES},
        '{'{8'h20, CL_SEP, 1'b0}, TYPED, 2'd1, '{1'b1, 8'h00, TK_SYMBOL, 1'b1}, NO_RES},
        '{'{8'h23, CL_SHELL, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h27, CL_QUOTE, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h2e, CL_DOT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h35, CL_DIGIT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h65, CL_EXPONENT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h2d, CL_SIGN, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h5d, CL_RBRACK, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h22, CL_STRDELIM, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h5c, CL_ESCAPE, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h22, CL_STRDELIM, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h00, CL_OTHER, 1'b1}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h2b, CL_SIGN, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h31, CL_DIGIT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h2e, CL_DOT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h3b, CL_COMMENT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h0a, CL_NEWLINE, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h21, CL_SHELL, 1'b0}, TYPED, 2'd0, NO_RES, NO_RES},
        '{'{8'h0a, CL_NEWLINE, 1'b0}, TYPED, 2'd0, NO_RES, NO_RES},
        '{'{8'h60, CL_MACRO, 1'b0}, TYPED, 2'd2, '{1'b0, 8'h60, TK_MACRO, 1'b0},
          '{1'b1, 8'h00, TK_MACRO, 1'b1}},
        '{'{8'h2c, CL_SPLICE, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h3a, CL_INFIX, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h2e, CL_DOT, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'h5b, CL_LBRACK, 1'b0}, PRED, 2'd0, NO_RES, NO_RES},
        '{'{8'hff, CL_TOP, 1'b1}, TYPED, 2'd0, NO_RES, NO_RES}
    };

    // Tokenizer state as the predictor sees it.
    scan_state_t  sc_state      = ST_START;
    tok_kind_t    sc_kind       = TK_SYMBOL;
    logic         sc_line_start = 1'b1;
    scan_result_t step_buf [MAX_RES];
    int           step_n;

    scan_result_t tok_expect_q [$];
    char_req_t    gen_q [$];

    int       fails          = 0;
    int       requests_sent  = 0;
    int       results_seen   = 0;
    int       ends_seen      = 0;
    int       pauses         = 0;
    logic [7:0] kinds_closed = '0;
    logic     no_idle        = 1'b0;
    logic     burst_send     = 1'b0;
    logic     hold_off_req   = 1'b0;
    logic     hold_done      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic is_terminator(logic [4:0] cl);
        return cl >= CL_SEP && cl <= CL_RBRACK;
    endfunction

    // Record one result of the current request; at most three fit.
    function automatic void note_result(logic is_end, logic [7:0] c);
        if (step_n < MAX_RES) begin
            step_buf[step_n] = '{is_end, c, sc_kind, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void close_open_token();
        note_result(1'b1, 8'h00);
        sc_state = ST_START;
        sc_kind  = TK_SYMBOL;
    endfunction

    // Work out the results of one request and advance the tokenizer state.
    function automatic void predict_step(char_req_t r);
        logic [4:0] cl;
        logic       rescan;
        int         pass;
        step_n = 0;
        if (r.flush) begin
            if (sc_state != ST_START && sc_state != ST_COMMENT) close_open_token();
            sc_state = ST_START;
            sc_kind  = TK_SYMBOL;
        end else begin
            cl     = (r.cls > CL_EXPONENT) ? CL_OTHER : r.cls;
            rescan = 1'b1;
            for (pass = 0; pass < 4 && rescan; pass++) begin
                rescan = 1'b0;
                case (sc_state)
                    ST_START: begin
                        if (sc_line_start && r.code == HASH_CHAR) begin
                            sc_state = ST_COMMENT;
                        end else begin
                            case (cl)
                                CL_SHELL: begin
                                    if (sc_line_start) begin
                                        sc_state = ST_COMMENT;
                                    end else begin
                                        sc_state = ST_HASH;
                                        sc_kind  = TK_SYMBOL;
                                        note_result(1'b0, r.code);
                                    end
                                end
                                CL_COMMENT: sc_state = ST_COMMENT;
                                CL_SEP, CL_NEWLINE: ;
                                CL_LPAREN, CL_RPAREN, CL_LBRACK, CL_RBRACK, CL_QUOTE: begin
                                    sc_kind = TK_SPECIAL;
                                    note_result(1'b0, r.code);
                                    close_open_token();
                                end
                                CL_DOT: begin
                                    sc_state = ST_DOT;
                                    sc_kind  = TK_SPECIAL;
                                    note_result(1'b0, r.code);
                                end
                                CL_STRDELIM: begin
                                    sc_state = ST_STRING;
                                    sc_kind  = TK_STRING;
                                end
                                CL_SIGN: begin
                                    sc_state = ST_SIGN;
                                    sc_kind  = TK_SYMBOL;
                                    note_result(1'b0, r.code);
                                end
                                CL_DIGIT: begin
                                    sc_state = ST_INT;
                                    sc_kind  = TK_INT;
                                    note_result(1'b0, r.code);
                                end
                                CL_MACRO, CL_SPLICE, CL_INFIX: begin
                                    sc_kind = (cl == CL_MACRO) ? TK_MACRO :
                                              (cl == CL_SPLICE) ? TK_SPLICE : TK_INFIX;
                                    note_result(1'b0, r.code);
                                    close_open_token();
                                end
                                default: begin
                                    sc_state = ST_SYMBOL;
                                    sc_kind  = TK_SYMBOL;
                                    note_result(1'b0, r.code);
                                end
                            endcase
                        end
                    end
                    ST_SYMBOL: begin
                        if (cl == CL_COMMENT || is_terminator(cl)) begin
                            close_open_token();
                            rescan = 1'b1;
                        end else if (cl == CL_ESCAPE) begin
                            sc_state = ST_SYMESC;
                        end else begin
                            note_result(1'b0, r.code);
                        end
                    end
                    ST_SYMESC: begin
                        note_result(1'b0, r.code);
                        sc_state = ST_SYMBOL;
                    end
                    ST_QUOTE: begin
                        note_result(1'b0, r.code);
                        sc_state = ST_STRING;
                    end
                    ST_STRING: begin
                        if (cl == CL_ESCAPE) begin
                            sc_state = ST_QUOTE;
                        end else if (cl == CL_STRDELIM) begin
                            close_open_token();
                        end else begin
                            note_result(1'b0, r.code);
                        end
                    end
                    ST_COMMENT: begin
                        if (cl == CL_NEWLINE) sc_state = ST_START;
                    end
                    ST_HASH: begin
                        if (is_terminator(cl)) begin
                            close_open_token();
                            rescan = 1'b1;
                        end else if (cl == CL_QUOTE) begin
                            note_result(1'b0, r.code);
                            close_open_token();
                        end else begin
                            note_result(1'b0, r.code);
                        end
                    end
                    ST_SIGN: begin
                        if (cl == CL_DIGIT) begin
                            sc_state = ST_INT;
                            sc_kind  = TK_INT;
                            note_result(1'b0, r.code);
                        end else begin
                            sc_state = ST_SYMBOL;
                            sc_kind  = TK_SYMBOL;
                            rescan   = 1'b1;
                        end
                    end
                    ST_INT, ST_FLOAT, ST_EXP1, ST_EXP2: begin
                        if (cl == CL_COMMENT || is_terminator(cl)) begin
                            close_open_token();
                            rescan = 1'b1;
                        end else begin
                            if (sc_state == ST_INT && cl == CL_DOT) begin
                                sc_state = ST_FLOAT;
                                sc_kind  = TK_FLOAT;
                            end else if ((sc_state == ST_INT || sc_state == ST_FLOAT) &&
                                         cl == CL_EXPONENT) begin
                                sc_state = ST_EXP1;
                                sc_kind  = TK_FLOAT;
                            end else if (cl == CL_DIGIT && sc_state != ST_EXP1) begin
                                // A digit keeps the number where it is.
                            end else if (sc_state == ST_EXP1 &&
                                         (cl == CL_SIGN || cl == CL_DIGIT)) begin
                                sc_state = ST_EXP2;
                            end else begin
                                sc_state = ST_SYMBOL;
                                sc_kind  = TK_SYMBOL;
                            end
                            note_result(1'b0, r.code);
                        end
                    end
                    ST_DOT: begin
                        // A lone dot is special; a digit makes it a float, anything else a symbol.
                        if (cl == CL_COMMENT || is_terminator(cl)) begin
                            close_open_token();
                        end else if (cl == CL_DIGIT) begin
                            sc_state = ST_FLOAT;
                            sc_kind  = TK_FLOAT;
                        end else begin
                            sc_state = ST_SYMBOL;
                            sc_kind  = TK_SYMBOL;
                        end
                        rescan = 1'b1;
                    end
                    default: begin
                        sc_state = ST_START;
                        sc_kind  = TK_SYMBOL;
                        rescan   = 1'b1;
                    end
                endcase
            end
            sc_line_start = (cl == CL_NEWLINE);
        end
        if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    endfunction

    function automatic void queue_result(scan_result_t r);
        tok_expect_q = {tok_expect_q, r};
        if (r.is_end) kinds_closed[r.kind] = 1'b1;
    endfunction

    // Random stimulus building blocks.
    function automatic void put_char(logic [7:0] c, logic [4:0] k);
        char_req_t r;
        r     = '{c, k, 1'b0};
        gen_q = {gen_q, r};
    endfunction

    function automatic void put_flush();
        char_req_t r;
        r     = '{8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 1'b1};
        gen_q = {gen_q, r};
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic void put_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) put_char(pick_digit(), CL_DIGIT);
    endfunction

    function automatic void put_exponent();
        put_char($urandom_range(0, 1) ? 8'h65 : 8'h45, CL_EXPONENT);
        if ($urandom_range(0, 1)) put_char($urandom_range(0, 1) ? 8'h2b : 8'h2d, CL_SIGN);
        put_digits(0, 2);
    endfunction

    // Queue one mostly well-formed token with random content, then mostly a terminator or a flush.
    function automatic void build_token();
        int         len;
        logic [4:0] k;
        len = $urandom_range(0, 6);
        case ($urandom_range(0, 13))
            0, 1: begin
                put_char(8'($urandom_range(8'h61, 8'h7a)), CL_OTHER);
                repeat (len) begin
                    if ($urandom_range(0, 5) == 0) begin
                        put_char(8'h5c, CL_ESCAPE);
                        put_char(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
                    end else begin
                        put_char(pick_letter(), CL_OTHER);
                    end
                end
            end
            2: begin
                if ($urandom_range(0, 1)) put_char($urandom_range(0, 1) ? 8'h2b : 8'h2d, CL_SIGN);
                put_digits(1, 4);
            end
            3: begin
                put_digits(1, 3);
                put_char(8'h2e, CL_DOT);
                put_digits(0, 3);
                if ($urandom_range(0, 1)) put_exponent();
            end
            4: begin
                put_char(8'h2e, CL_DOT);
                put_digits(1, 3);
                if ($urandom_range(0, 2) == 0) put_exponent();
            end
            5: begin
                put_char(8'h22, CL_STRDELIM);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0) begin
                        put_char(8'h5c, CL_ESCAPE);
                        put_char(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
                    end else begin
                        k = 5'($urandom_range(0, 31));
                        if (k == CL_STRDELIM || k == CL_ESCAPE) k = CL_OTHER;
                        put_char(8'($urandom_range(0, 255)), k);
                    end
                end
                if ($urandom_range(0, 7) == 0) put_flush();
                else put_char(8'h22, CL_STRDELIM);
            end
            6: begin
                put_char(8'h3b, CL_COMMENT);
                repeat (len) begin
                    k = 5'($urandom_range(0, 31));
                    if (k == CL_NEWLINE) k = CL_OTHER;
                    put_char(8'($urandom_range(0, 255)), k);
                end
                put_char(8'h0a, CL_NEWLINE);
            end
            7: begin
                // A hash right after a newline opens a comment whatever its class.
                put_char(8'h0a, CL_NEWLINE);
                put_char(HASH_CHAR, 5'($urandom_range(0, 31)));
                repeat (len) put_char(pick_letter(), CL_OTHER);
                put_char(8'h0a, CL_NEWLINE);
            end
            8: begin
                case ($urandom_range(0, 4))
                    0: put_char(8'h28, CL_LPAREN);
                    1: put_char(8'h29, CL_RPAREN);
                    2: put_char(8'h5b, CL_LBRACK);
                    3: put_char(8'h5d, CL_RBRACK);
                    default: put_char(8'h27, CL_QUOTE);
                endcase
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: put_char(8'h60, CL_MACRO);
                    1: put_char(8'h2c, CL_SPLICE);
                    default: put_char(8'h3a, CL_INFIX);
                endcase
            end
            10: begin
                put_char(HASH_CHAR, CL_SHELL);
                put_digits(0, 1);
                repeat ($urandom_range(1, 3)) put_char(pick_letter(), CL_OTHER);
                if ($urandom_range(0, 1)) put_char(8'h27, CL_QUOTE);
            end
            11: begin
                put_char($urandom_range(0, 1) ? 8'h2b : 8'h2d, CL_SIGN);
                repeat ($urandom_range(0, 3)) put_char(pick_letter(), CL_OTHER);
            end
            12: begin
                // Numbers broken by whatever class comes next.
                put_digits(1, 2);
                repeat ($urandom_range(1, 3))
                    put_char(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) == 0) put_flush();
                    else put_char(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
                end
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: put_char(8'h20, CL_SEP);
            3: put_char(8'h09, CL_SEP);
            4: put_char(8'h0a, CL_NEWLINE);
            5: put_char(8'h29, CL_RPAREN);
            6: put_char(8'h28, CL_LPAREN);
            7: begin
                put_char(8'h3b, CL_COMMENT);
                put_char(8'h0a, CL_NEWLINE);
            end
            8: put_flush();
            default: ;
        endcase
    endfunction

    // Offer one request and return at the rising edge that accepts it.
    task automatic send_request(char_req_t r);
        int gap;
        gap = (no_idle || burst_send) ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.cls, r.code};
        s_tuser  <= r.flush;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Stop offering requests until every pending result has come out.
    task automatic drain_wait();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tok_expect_q.size() != 0) @(negedge aclk);
        pauses++;
    endtask

    // Request side: reset, directed rows, then random token streams.
    initial begin : request_source
        char_req_t req;
        int        i;
        int        rnd_sent;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].req);
            predict_step(dir_rows[i].req);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].n_typed >= 2'd1) queue_result(dir_rows[i].r0);
                if (dir_rows[i].n_typed >= 2'd2) queue_result(dir_rows[i].r1);
            end else begin
                for (int j = 0; j < step_n; j++) queue_result(step_buf[j]);
            end
        end

        rnd_sent = 0;
        while (rnd_sent < RANDOM_ITEMS) begin
            if (gen_q.size() == 0) build_token();
            req = gen_q.pop_front();
            if (rnd_sent == 60 || rnd_sent == 260) drain_wait();
            no_idle    = (rnd_sent >= 120 && rnd_sent < 170);
            burst_send = (rnd_sent >= 200 && rnd_sent < 240);
            if (rnd_sent == 200) hold_off_req = 1'b1;
            send_request(req);
            predict_step(req);
            for (int j = 0; j < step_n; j++) queue_result(step_buf[j]);
            rnd_sent++;
        end

        // Let everything drain, then keep watching for stray results before the final checks.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tok_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tok_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", tok_expect_q.size());
            fails += tok_expect_q.size();
        end
        $display("Scanned %0d requests (%0d directed) into %0d results, %0d token ends.",
                 requests_sent, DIR_ROWS, results_seen, ends_seen);
        $display("Token types closed (one bit each): %08b; long output hold-off %0s; %0d drains.",
                 kinds_closed, hold_done ? "done" : "missed", pauses);
        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, and the field checks.
    initial begin : result_sink
        scan_result_t got;
        scan_result_t want;
        int           stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                hold_done    = 1'b1;
            end
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);

            got = '{m_tuser, m_tdata[7:0], tok_kind_t'(m_tdata[10:8]), m_tlast};
            results_seen++;
            if (got.is_end === 1'b1) ends_seen++;
            if (tok_expect_q.size() == 0) begin
                $error("result with no request pending: result_kind %0d out_char %02h",
                       got.is_end, got.ch);
                fails++;
            end else begin
                want = tok_expect_q.pop_front();
                if (got.is_end !== want.is_end) begin
                    $error("result_kind: expected %0d, got %0d", want.is_end, got.is_end);
                    fails++;
                end
                if (got.ch !== want.ch) begin
                    $error("out_char: expected %02h, got %02h", want.ch, got.ch);
                    fails++;
                end
                if (got.kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
                    fails++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fails++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $error("no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== lisp_token_scanner.f =====
src/lts_pkg.sv
src/lts_scan_core.sv
src/lts_result_fifo.sv
src/lisp_token_scanner.sv
tb/lisp_token_scanner_test.sv
